### rtl/core/blr_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
// Used by blr_step_unit and bresenham_line_rasterizer; no dependencies.
`timescale 1ns / 1ps

package blr_pkg;

    localparam int COORD_BITS = 6;
    localparam int ERR_BITS   = 8;
    localparam int COLOR_BITS = 16;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } blr_state_t;

    // Walk state handed to the step unit
    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        err_t   step_error;
        coord_t major_delta;
        coord_t minor_delta;
        coord_t end_major;
        logic   x_goes_down;
        logic   y_goes_down;
        logic   steep;
    } blr_walk_t;

    // Result of one step
    typedef struct packed {
        coord_t next_x;
        coord_t next_y;
        err_t   next_error;
        logic   done;
    } blr_advance_t;

endpackage

### rtl/core/blr_step_unit.sv
// Shared step unit: advances the walk by one pixel along the major axis.
// Depends on blr_pkg.
`timescale 1ns / 1ps

module blr_step_unit (
    input  blr_pkg::blr_walk_t    walk,
    output blr_pkg::blr_advance_t adv
);
    import blr_pkg::*;

    coord_t major_cur;
    err_t   err_sum;
    err_t   half_major;
    logic   minor_step;
    coord_t x_moved;
    coord_t y_moved;

    always_comb begin
        major_cur  = walk.steep ? walk.cur_y : walk.cur_x;
        err_sum    = walk.step_error + err_t'({2'b00, walk.minor_delta});
        half_major = err_t'({3'b000, walk.major_delta[COORD_BITS-1:1]});
        minor_step = (walk.minor_delta != '0) && (err_sum >= half_major);

        x_moved = walk.x_goes_down ? walk.cur_x - coord_t'(1) : walk.cur_x + coord_t'(1);
        y_moved = walk.y_goes_down ? walk.cur_y - coord_t'(1) : walk.cur_y + coord_t'(1);

        adv.done       = (major_cur == walk.end_major);
        adv.next_error = minor_step ? err_sum - err_t'({2'b00, walk.major_delta}) : err_sum;
        if (walk.steep) begin
            adv.next_y = y_moved;
            adv.next_x = minor_step ? x_moved : walk.cur_x;
        end else begin
            adv.next_x = x_moved;
            adv.next_y = minor_step ? y_moved : walk.cur_y;
        end
    end

endmodule

### rtl/core/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: request intake, walk registers
// and pixel output. Depends on blr_pkg and blr_step_unit.
`timescale 1ns / 1ps

// Usage:
//   The slave channel takes one line request per transaction: two endpoints
//   and a 16-bit color. The master channel then emits every pixel of the line
//   from the start point to the end point, one transaction per pixel, with
//   m_tlast high on the pixel at the end point. A zero-length line gives one
//   pixel with m_tlast set.
//   Timing: the first pixel is presented the cycle after the request is
//   accepted. A line of major delta D gives D + 1 pixels, one pixel per cycle
//   while m_tready does not stall, and a new request is accepted only after the
//   last pixel is taken. All endpoints lie within the 64 x 64 tile.
//   The pixel rate is set by the single shared step unit, which advances the
//   walk by one pixel each time a pixel other than the last is taken.
//   s_tready is high only while no line is being walked.
//   A stall on m_tready holds the current pixel on m_tdata and freezes the
//   walk until the pixel is taken.
//   Reset (aresetn low, synchronous) drops any line in progress and returns
//   the block to idle with s_tready high and m_tvalid low.

module bresenham_line_rasterizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18], color[39:24]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: pixel_x[5:0], pixel_y[11:6], pixel_color[27:12], zero[31:28]
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    import blr_pkg::*;

    blr_state_t state_reg, state_next;
    blr_walk_t  walk_reg, walk_next;
    logic [COLOR_BITS-1:0] color_hold_reg;
    blr_advance_t adv;

    logic   in_fire;
    logic   out_fire;
    coord_t xs, ys, xe, ye;
    coord_t dx, dy;
    logic   x_up, y_up, steep_in;

    assign xs = s_tdata[5:0];
    assign ys = s_tdata[11:6];
    assign xe = s_tdata[17:12];
    assign ye = s_tdata[23:18];

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    blr_step_unit u_step (
        .walk (walk_reg),
        .adv  (adv)
    );

    // Request setup
    always_comb begin
        x_up     = xe > xs;
        y_up     = ye > ys;
        dx       = x_up ? xe - xs : xs - xe;
        dy       = y_up ? ye - ys : ys - ye;
        steep_in = !(dx >= dy);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_fire && adv.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and walk update
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        walk_next = walk_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    walk_next.cur_x       = xs;
                    walk_next.cur_y       = ys;
                    walk_next.step_error  = '0;
                    walk_next.steep       = steep_in;
                    walk_next.major_delta = steep_in ? dy : dx;
                    walk_next.minor_delta = steep_in ? dx : dy;
                    walk_next.end_major   = steep_in ? ye : xe;
                    walk_next.x_goes_down = !x_up;
                    walk_next.y_goes_down = !y_up;
                end
            end
            ST_RUN: begin
                m_tvalid = 1'b1;
                // advance only when the pixel is taken and more remain
                if (m_tready && !adv.done) begin
                    walk_next.cur_x      = adv.next_x;
                    walk_next.cur_y      = adv.next_y;
                    walk_next.step_error = adv.next_error;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tdata = {4'b0000, color_hold_reg, walk_reg.cur_y, walk_reg.cur_x};
    assign m_tlast = adv.done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            walk_reg  <= '0;
        end else begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_hold_reg <= '0;
        end else if (in_fire) begin
            color_hold_reg <= s_tdata[39:24];
        end
    end

    // Assertions
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a pixel is pending");

    a_first_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_tvalid)
        else $error("no pixel after accepted request");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_tlast) |=> s_tready)
        else $error("block not idle after last pixel");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (walk_reg.step_error >= -8'sd63 && walk_reg.step_error <= 8'sd94))
        else $error("step error out of range");

endmodule
